>>> sv/mubn_pkg.sv
// Shared constants, codes and types of the unit box normalizer.
`default_nettype none

package mubn_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int NUM_AXES        = 3;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ACCUM = 2'd1,
        KIND_XFORM = 2'd2
    } kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // One queued transform: the point's three coordinates, three numerators, three extents.
    function automatic int entry_bits(input int cw);
        return 9 * cw + 9;
    endfunction

endpackage

`default_nettype wire

>>> sv/mubn_ifs.sv
// Valid/ready channel interfaces for vertex items and normalized results.
`default_nettype none

interface mubn_in_if #(
    parameter int COORD_WIDTH = mubn_pkg::DEF_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;

    modport source (output valid, output kind, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input kind, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

interface mubn_out_if #(
    parameter int COORD_WIDTH = mubn_pkg::DEF_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] norm_x;
    logic signed [COORD_WIDTH-1:0] norm_y;
    logic signed [COORD_WIDTH-1:0] norm_z;
    logic                          degenerate;

    modport source (output valid, output norm_x, output norm_y, output norm_z,
                    output degenerate, input ready);
    modport sink   (input valid, input norm_x, input norm_y, input norm_z,
                    input degenerate, output ready);
endinterface

`default_nettype wire

>>> sv/mubn_front.sv
// Front end: accepts items, tracks the bounding box, queues transform work.
`default_nettype none

module mubn_front #(
    parameter int COORD_WIDTH = mubn_pkg::DEF_COORD_WIDTH
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    mubn_in_if.sink                                                 req,
    input  mubn_pkg::qstat_t                                        qstat,
    output logic                                                    push,
    output logic [mubn_pkg::entry_bits(COORD_WIDTH)-1:0]            push_data
);
    import mubn_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] box_min_reg [NUM_AXES];
    logic signed [CW-1:0] box_min_next[NUM_AXES];
    logic signed [CW-1:0] box_max_reg [NUM_AXES];
    logic signed [CW-1:0] box_max_next[NUM_AXES];
    logic signed [CW-1:0] coord       [NUM_AXES];
    logic signed [CW+1:0] num         [NUM_AXES];
    logic signed [CW:0]   ext         [NUM_AXES];
    logic                 accept;
    kind_t                item_kind;

    assign coord[0]  = req.coord_x;
    assign coord[1]  = req.coord_y;
    assign coord[2]  = req.coord_z;
    assign item_kind = kind_t'(req.kind);

    assign req.ready = !qstat.full;
    assign accept    = req.valid && req.ready;
    assign push      = accept && (item_kind == KIND_XFORM);

    // Snapshot of the box as seen by this transform: 2p - min - max and max - min.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            num[i] = (CW+2)'(coord[i]) + (CW+2)'(coord[i])
                   - (CW+2)'(box_min_reg[i]) - (CW+2)'(box_max_reg[i]);
            ext[i] = (CW+1)'(box_max_reg[i]) - (CW+1)'(box_min_reg[i]);
        end
    end

    assign push_data = {coord[0], coord[1], coord[2],
                        num[0], num[1], num[2],
                        ext[0], ext[1], ext[2]};

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            box_min_next[i] = box_min_reg[i];
            box_max_next[i] = box_max_reg[i];
        end
        if (accept)
        begin
            case (item_kind)
                KIND_CLEAR:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        box_min_next[i] = MAXV;
                        box_max_next[i] = MINV;
                    end
                end
                KIND_ACCUM:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        if (coord[i] < box_min_reg[i])
                        begin
                            box_min_next[i] = coord[i];
                        end
                        if (coord[i] > box_max_reg[i])
                        begin
                            box_max_next[i] = coord[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_min_reg[i] <= MAXV;
                box_max_reg[i] <= MINV;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_min_reg[i] <= box_min_next[i];
                box_max_reg[i] <= box_max_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/mubn_queue.sv
// Short flop queue that decouples the front end from the divider.
`default_nettype none

module mubn_queue #(
    parameter int WIDTH = mubn_pkg::entry_bits(mubn_pkg::DEF_COORD_WIDTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output mubn_pkg::qstat_t        qstat
);
    import mubn_pkg::*;

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign qstat.full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue pushed while full");

endmodule

`default_nettype wire

>>> sv/mubn_back.sv
// Back end: three-lane restoring divider and result register.
`default_nettype none

module mubn_back #(
    parameter int COORD_WIDTH = mubn_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mubn_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  mubn_pkg::qstat_t                                    qstat,
    input  wire logic [mubn_pkg::entry_bits(COORD_WIDTH)-1:0]   pop_data,
    output logic                                                pop,
    mubn_out_if.source                                          rsp
);
    import mubn_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int EW   = entry_bits(CW);
    localparam int MW   = CW + 1 + FB;          // magnitude shifted by the fraction
    localparam int TW   = FB + 2;               // bits above the quotient field
    localparam int DW   = CW + 1;               // divisor and remainder
    localparam int XW   = (TW > DW) ? TW : DW;
    localparam int QW   = CW - 1;               // quotient bits below saturation
    localparam int CNTW = $clog2(QW);
    localparam int NUM_OFS = 3 * (CW + 1);
    localparam int P_OFS   = 3 * (CW + 1) + 3 * (CW + 2);
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREP  = 5'b00010,
        S_CHECK = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [EW-1:0]        ent_reg, ent_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic [DW-1:0]        den_reg, den_next;
    logic                 deg_reg, deg_next;
    logic                 neg_reg [NUM_AXES];
    logic                 neg_next[NUM_AXES];
    logic                 sat_reg [NUM_AXES];
    logic                 sat_next[NUM_AXES];
    logic [CW:0]          mag_reg [NUM_AXES];
    logic [CW:0]          mag_next[NUM_AXES];
    logic [DW-1:0]        rem_reg [NUM_AXES];
    logic [DW-1:0]        rem_next[NUM_AXES];
    logic [QW-1:0]        low_reg [NUM_AXES];
    logic [QW-1:0]        low_next[NUM_AXES];
    logic [QW-1:0]        quo_reg [NUM_AXES];
    logic [QW-1:0]        quo_next[NUM_AXES];
    logic signed [CW-1:0] norm_reg [NUM_AXES];
    logic signed [CW-1:0] norm_next[NUM_AXES];
    logic                 out_deg_reg, out_deg_next;
    logic                 out_valid_reg, out_valid_next;

    logic signed [CW-1:0] pnt     [NUM_AXES];
    logic signed [CW+1:0] num     [NUM_AXES];
    logic signed [CW+1:0] mag_full[NUM_AXES];
    logic signed [CW:0]   ext     [NUM_AXES];
    logic signed [CW:0]   big_xy, big;
    logic [MW-1:0]        m_wide  [NUM_AXES];
    logic [TW-1:0]        top     [NUM_AXES];
    logic [DW:0]          r2      [NUM_AXES];
    logic [DW:0]          diff    [NUM_AXES];
    logic                 ge      [NUM_AXES];
    logic                 out_load;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            ext[i] = ent_reg[(2 - i) * (CW + 1) +: CW + 1];
            num[i] = ent_reg[NUM_OFS + (2 - i) * (CW + 2) +: CW + 2];
            pnt[i] = ent_reg[P_OFS + (2 - i) * CW +: CW];
        end
    end

    // Largest extent, magnitude and sign of each numerator.
    always_comb
    begin
        big_xy = (ext[1] > ext[0]) ? ext[1] : ext[0];
        big    = (ext[2] > big_xy) ? ext[2] : big_xy;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag_full[i] = num[i][CW+1] ? -num[i] : num[i];
        end
    end

    // Saturation check and one restoring step per lane.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            m_wide[i] = {mag_reg[i], {FB{1'b0}}};
            top[i]    = m_wide[i][MW-1:CW-1];
            r2[i]     = {rem_reg[i], low_reg[i][QW-1]};
            diff[i]   = r2[i] - (DW+1)'(den_reg);
            ge[i]     = (r2[i] >= (DW+1)'(den_reg));
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign pop      = !qstat.empty && ((state_reg == S_IDLE) || out_load);

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        cnt_next       = cnt_reg;
        den_next       = den_reg;
        deg_next       = deg_reg;
        out_deg_next   = out_deg_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            neg_next[i]  = neg_reg[i];
            sat_next[i]  = sat_reg[i];
            mag_next[i]  = mag_reg[i];
            rem_next[i]  = rem_reg[i];
            low_next[i]  = low_reg[i];
            quo_next[i]  = quo_reg[i];
            norm_next[i] = norm_reg[i];
        end

        if (pop)
        begin
            ent_next = pop_data;
        end

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                deg_next = big[CW] || (big == '0);
                den_next = {big[CW-1:0], 1'b0};
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    neg_next[i] = num[i][CW+1];
                    mag_next[i] = mag_full[i][CW:0];
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    sat_next[i] = (XW'(top[i]) >= XW'(den_reg));
                    rem_next[i] = DW'(top[i]);
                    low_next[i] = m_wide[i][QW-1:0];
                    quo_next[i] = '0;
                end
                cnt_next   = '0;
                state_next = deg_reg ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    rem_next[i] = ge[i] ? diff[i][DW-1:0] : r2[i][DW-1:0];
                    low_next[i] = {low_reg[i][QW-2:0], 1'b0};
                    quo_next[i] = {quo_reg[i][QW-2:0], ge[i]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        if (deg_reg)
                        begin
                            norm_next[i] = pnt[i];
                        end
                        else if (sat_reg[i])
                        begin
                            norm_next[i] = neg_reg[i] ? MINV : MAXV;
                        end
                        else
                        begin
                            norm_next[i] = neg_reg[i] ? -{1'b0, quo_reg[i]}
                                                      : {1'b0, quo_reg[i]};
                        end
                    end
                    out_deg_next   = deg_reg;
                    out_valid_next = 1'b1;
                    state_next     = pop ? S_PREP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg     <= ent_next;
        cnt_reg     <= cnt_next;
        den_reg     <= den_next;
        deg_reg     <= deg_next;
        out_deg_reg <= out_deg_next;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            neg_reg[i]  <= neg_next[i];
            sat_reg[i]  <= sat_next[i];
            mag_reg[i]  <= mag_next[i];
            rem_reg[i]  <= rem_next[i];
            low_reg[i]  <= low_next[i];
            quo_reg[i]  <= quo_next[i];
            norm_reg[i] <= norm_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.norm_x     = norm_reg[0];
    assign rsp.norm_y     = norm_reg[1];
    assign rsp.norm_z     = norm_reg[2];
    assign rsp.degenerate = out_deg_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= CNTW'(QW - 1)))
        else $error("divider step count overran");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !sat_reg[0]) |-> (rem_reg[0] < den_reg))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> sv/mesh_unit_box_normalize_core.sv
// Top level of the mesh unit box normalizer: front end, queue and divider.
//
// Usage: the host streams each vertex twice over the req channel. A clear
// transaction (kind 0) empties the running box, accumulate transactions
// (kind 1) grow it, and each transform transaction (kind 2) yields one
// result on rsp: (p - centre) / largest extent in signed Q(FRAC_BITS)
// fixed point, truncated toward zero and saturated, or the point unchanged
// with degenerate set when the largest extent is not positive. Kind 3 is
// ignored. Clear and accumulate transactions produce no result.
// Clear and accumulate transactions are accepted whenever the queue has
// room. In the back end a transform passes a setup state, a saturation
// check and COORD_WIDTH - 1 restoring steps of the three-lane divider,
// then a result state; a degenerate transform skips the restoring steps.
// The box is snapshotted at accept time, so box updates that follow a
// transform never alter its result. A two-entry queue parts front and back.
// Reset empties the box, the queue and the result register. When the
// receiver stalls, the result holds on rsp, the back end waits, and req
// keeps flowing until the queue fills.
`default_nettype none

module mesh_unit_box_normalize_core #(
    parameter int COORD_WIDTH = mubn_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mubn_pkg::DEF_FRAC_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mubn_in_if.sink     req,
    mubn_out_if.source  rsp
);
    import mubn_pkg::*;

    localparam int EW = entry_bits(COORD_WIDTH);

    qstat_t        qstat;
    logic          push;
    logic          pop;
    logic [EW-1:0] push_data;
    logic [EW-1:0] pop_data;

    // Accept items, keep the box, queue transform snapshots.
    mubn_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // Hold pending transforms so the front keeps taking transactions.
    mubn_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // Divide, saturate and drive the result register.
    mubn_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

>>> sim/mesh_unit_box_normalize_core_tb.sv
// Self-checking testbench for the mesh unit box normalizer core.
module mesh_unit_box_normalize_core_tb;

    import mubn_pkg::*;

    localparam int COORD_W = DEF_COORD_WIDTH;
    localparam int FRAC    = DEF_FRAC_BITS;
    localparam int CYCLE   = 10;
    // Wait after the drain, long enough for the back end to finish a transform.
    localparam int SETTLE  = COORD_W + 8;

    // Kind 3 has no name in the package; the block must ignore it.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t nx;
        coord_t ny;
        coord_t nz;
        logic   degen;
    } norm_t;

    // Running bounding box plus the queue of normalized points still owed.
    class unit_box_tracker;
        longint lo_x, lo_y, lo_z;
        longint hi_x, hi_y, hi_z;
        norm_t  expected_norms[$];
        int     mismatches;

        function new();
            empty_box();
            mismatches = 0;
        endfunction

        function void empty_box();
            lo_x = COORD_MAX; lo_y = COORD_MAX; lo_z = COORD_MAX;
            hi_x = COORD_MIN; hi_y = COORD_MIN; hi_z = COORD_MIN;
        endfunction

        // (2p - lo - hi) * 2^FRAC / den, truncated toward zero, saturated.
        function coord_t fit_axis(longint p, longint lo, longint hi, longint den);
            longint          num;
            longint unsigned mag, d, q, r, cap;
            bit              neg, sat;
            int              i;
            num = 2 * p - lo - hi;
            neg = num < 0;
            mag = neg ? -num : num;
            d   = den;
            cap = longint'(1) << (COORD_W - 1);
            q   = mag / d;
            r   = mag % d;
            sat = 1'b0;
            if (q > cap) begin
                q   = cap;
                sat = 1'b1;
            end
            for (i = 0; i < FRAC && !sat; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
                if (q > cap) begin
                    q   = cap;
                    sat = 1'b1;
                end
            end
            if (neg)
                return coord_t'(-q);
            if (q > cap - 1)
                q = cap - 1;
            return coord_t'(q);
        endfunction

        function void note_vertex(logic [1:0] k, coord_t x, coord_t y, coord_t z);
            longint px, py, pz, ex, ey, ez, big;
            norm_t  n;
            px = x;
            py = y;
            pz = z;
            case (k)
                KIND_CLEAR: empty_box();
                KIND_ACCUM:
                begin
                    if (px < lo_x) lo_x = px;
                    if (py < lo_y) lo_y = py;
                    if (pz < lo_z) lo_z = pz;
                    if (px > hi_x) hi_x = px;
                    if (py > hi_y) hi_y = py;
                    if (pz > hi_z) hi_z = pz;
                end
                KIND_XFORM:
                begin
                    ex  = hi_x - lo_x;
                    ey  = hi_y - lo_y;
                    ez  = hi_z - lo_z;
                    big = ex;
                    if (ey > big) big = ey;
                    if (ez > big) big = ez;
                    if (big <= 0)
                    begin
                        n.nx    = x;
                        n.ny    = y;
                        n.nz    = z;
                        n.degen = 1'b1;
                    end
                    else
                    begin
                        n.nx    = fit_axis(px, lo_x, hi_x, 2 * big);
                        n.ny    = fit_axis(py, lo_y, hi_y, 2 * big);
                        n.nz    = fit_axis(pz, lo_z, hi_z, 2 * big);
                        n.degen = 1'b0;
                    end
                    expected_norms.insert(expected_norms.size(), n);
                end
                default: ;
            endcase
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 100)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_norm(coord_t nx, coord_t ny, coord_t nz, logic dg);
            norm_t w;
            if (expected_norms.size() == 0)
            begin
                flag_mismatch($sformatf("unrequested result %h %h %h degenerate=%b",
                                        nx, ny, nz, dg));
                return;
            end
            w = expected_norms.pop_front();
            if (nx !== w.nx) flag_mismatch($sformatf("norm_x %h, want %h", nx, w.nx));
            if (ny !== w.ny) flag_mismatch($sformatf("norm_y %h, want %h", ny, w.ny));
            if (nz !== w.nz) flag_mismatch($sformatf("norm_z %h, want %h", nz, w.nz));
            if (dg !== w.degen)
                flag_mismatch($sformatf("degenerate %b, want %b", dg, w.degen));
        endtask

        task close_out();
            if (expected_norms.size() != 0)
                flag_mismatch($sformatf("%0d results never arrived", expected_norms.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    mubn_in_if  #(.COORD_WIDTH(COORD_W)) req_if ();
    mubn_out_if #(.COORD_WIDTH(COORD_W)) rsp_if ();

    mesh_unit_box_normalize_core #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    unit_box_tracker boxes = new();

    // Idle and stall rates in percent, changed per phase by the stimulus.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // Cycles left in a forced receiver hold-off.
    int hold_off_left  = 0;
    // Items offered that the block acts on; kind 3 is not counted.
    int items_offered  = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CYCLE / 2) clk = ~clk;
    end

    // Receiver: stall at random, or hold ready low for a counted stretch.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_off_left--;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor both channels; values read here are the ones before the edge.
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            boxes.note_vertex(req_if.kind, req_if.coord_x, req_if.coord_y, req_if.coord_z);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            boxes.check_norm(rsp_if.norm_x, rsp_if.norm_y, rsp_if.norm_z,
                             rsp_if.degenerate);
    end

    // Offer one transaction, idling at random first, and hold it until taken.
    // Valid stays high on return so back-to-back items need no dip.
    task automatic send_item(input logic [1:0] k, input coord_t x, input coord_t y,
                             input coord_t z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.kind    <= k;
        req_if.coord_x <= x;
        req_if.coord_y <= y;
        req_if.coord_z <= z;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (k != KIND_SPARE)
            items_offered++;
    endtask

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_MAX) return coord_t'(COORD_MAX);
        if (v < COORD_MIN) return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    // Full-range value, biased toward the extremes, zero and minus one.
    function automatic coord_t any_coord();
        case ($urandom_range(7))
            0: return coord_t'(COORD_MAX);
            1: return coord_t'(COORD_MIN);
            2: return '0;
            3: return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // One well-formed mesh: clear, accumulate every vertex, then transform
    // them again. Style picks the shape: ordinary, full range, tiny box
    // (drives saturation), or flat along one axis (unequal extents).
    task automatic send_mesh(input int n, input int style);
        coord_t vx[16], vy[16], vz[16];
        longint cx, cy, cz, sx, sy, sz;
        int     i, j;
        cx = jitter(1 << 24);
        cy = jitter(1 << 24);
        cz = jitter(1 << 24);
        sx = 1 + $urandom_range(1 << 20);
        sy = 1 + $urandom_range(1 << 20);
        sz = 1 + $urandom_range(1 << 20);
        if (style == 2)
        begin
            cx = jitter(1 << 30);
            cy = jitter(1 << 30);
            cz = jitter(1 << 30);
            sx = $urandom_range(3);
            sy = $urandom_range(3);
            sz = $urandom_range(3);
        end
        else if (style == 3)
        begin
            case ($urandom_range(2))
                0: sx = 0;
                1: sy = 0;
                default: sz = 0;
            endcase
        end
        for (i = 0; i < n; i++)
        begin
            if (style == 1)
            begin
                vx[i] = any_coord();
                vy[i] = any_coord();
                vz[i] = any_coord();
            end
            else
            begin
                vx[i] = clamp_coord(cx + jitter(sx));
                vy[i] = clamp_coord(cy + jitter(sy));
                vz[i] = clamp_coord(cz + jitter(sz));
            end
        end
        // Skip the clear now and then so boxes carry over between meshes.
        if ($urandom_range(9) != 0)
            send_item(KIND_CLEAR, any_coord(), any_coord(), any_coord());
        for (i = 0; i < n; i++)
        begin
            send_item(KIND_ACCUM, vx[i], vy[i], vz[i]);
            if ($urandom_range(19) == 0)
                send_item(KIND_SPARE, any_coord(), any_coord(), any_coord());
        end
        for (i = 0; i < n; i++)
        begin
            j = ($urandom_range(9) == 0) ? $urandom_range(n - 1) : i;
            send_item(KIND_XFORM, vx[j], vy[j], vz[j]);
        end
        // A stray point, often far outside the box.
        if ($urandom_range(3) == 0)
            send_item(KIND_XFORM, any_coord(), any_coord(), any_coord());
    endtask

    // Unstructured transactions of any kind.
    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_item(2'($urandom_range(3)), any_coord(), any_coord(), any_coord());
    endtask

    task automatic run_phase(input int goal);
        int stop_at;
        stop_at = items_offered + goal;
        while (items_offered < stop_at)
        begin
            if ($urandom_range(9) == 0)
                send_noise($urandom_range(1, 4));
            else
                send_mesh($urandom_range(1, 12), $urandom_range(3));
        end
    endtask

    // Edge cases: empty box, ignored kind, single-point box, full-range box,
    // one-LSB box with saturation both ways, and rounding of negative values.
    task automatic run_directed();
        coord_t cmax, cmin;
        cmax = coord_t'(COORD_MAX);
        cmin = coord_t'(COORD_MIN);
        send_item(KIND_XFORM, cmin, cmax, '0);
        send_item(KIND_SPARE, 5, 5, 5);
        send_item(KIND_XFORM, 1, '1, coord_t'(32'h7fff_0000));
        send_item(KIND_ACCUM, coord_t'(32'h0001_0000), coord_t'(32'h0002_0000),
                  coord_t'(32'h0003_0000));
        send_item(KIND_XFORM, coord_t'(32'h0001_0000), coord_t'(32'h0002_0000),
                  coord_t'(32'h0003_0000));
        send_item(KIND_ACCUM, cmin, cmin, cmin);
        send_item(KIND_ACCUM, cmax, '0, '1);
        send_item(KIND_XFORM, cmin, cmin, cmin);
        send_item(KIND_XFORM, cmax, cmax, cmax);
        send_item(KIND_XFORM, '0, '1, 1);
        send_item(KIND_CLEAR, cmax, cmax, cmax);
        send_item(KIND_XFORM, 7, 8, 9);
        send_item(KIND_ACCUM, '0, '0, '0);
        send_item(KIND_ACCUM, 1, '0, '0);
        send_item(KIND_XFORM, cmax, cmin, '0);
        send_item(KIND_XFORM, 1, '0, '0);
        send_item(KIND_XFORM, '0, 1, '1);
        send_item(KIND_ACCUM, 3, 3, 3);
        send_item(KIND_XFORM, 1, 2, '0);
        send_item(KIND_SPARE, cmax, cmax, cmax);
        send_item(KIND_XFORM, 2, 2, 2);
        send_item(KIND_CLEAR, '0, '0, '0);
        send_item(KIND_XFORM, cmax, cmin, '1);
    endtask

    initial
    begin
        req_if.valid   = 1'b0;
        req_if.kind    = KIND_CLEAR;
        req_if.coord_x = '0;
        req_if.coord_y = '0;
        req_if.coord_z = '0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Full speed, then fill the block: hold the receiver off while the
        // sender keeps streaming transforms until input backs up.
        run_phase(350);
        hold_off_left = 400;
        send_mesh(12, 0);

        // Sender idle only.
        src_idle_pct   = 57;
        sink_stall_pct = 0;
        run_phase(400);

        // Receiver stalling only.
        src_idle_pct   = 0;
        sink_stall_pct = 57;
        run_phase(400);

        // Both sides idling.
        src_idle_pct   = 36;
        sink_stall_pct = 36;
        run_phase(400);

        // Back to full speed for the tail.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_phase(400);

        // Drop valid, drain the owed results, then watch for strays.
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (boxes.expected_norms.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        boxes.close_out();

        if (boxes.mismatches == 0)
            $display("mesh_unit_box_normalize_core_tb: clean");
        else
            $display("mesh_unit_box_normalize_core_tb: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(CYCLE * 1000000);
        $display("mesh_unit_box_normalize_core_tb: errors");
        $finish;
    end

endmodule
